// ===== design/ptup_pkg.sv =====
// ptup_pkg: shared types and constants for the per-task usage and peak table
// holds the event mode codes and the packed input and result transfer types
// no dependencies
`default_nettype none

package ptup_pkg;

    localparam int unsigned ID_W  = 8;
    localparam int unsigned AMT_W = 32;

    // event mode codes
    typedef enum logic [1:0] {
        MODE_INC = 2'd0,
        MODE_DEC = 2'd1,
        MODE_CLR = 2'd2,
        MODE_QRY = 2'd3
    } t_mode;

    // one input event
    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   task_id;
        logic [AMT_W-1:0]  amount;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [AMT_W-1:0]  task_used;
        logic [AMT_W-1:0]  task_peak;
        logic [AMT_W-1:0]  total_used;
        logic [AMT_W-1:0]  total_peak;
        logic              refused;
    } t_out_item;

    // one table entry as held in memory
    typedef struct packed {
        logic [AMT_W-1:0]  used;
        logic [AMT_W-1:0]  peak;
    } t_entry;

endpackage

`default_nettype wire

// ===== design/per_task_usage_peak_table_core.sv =====
// per_task_usage_peak_table_core: per-task memory usage and peak accounting table
// one synchronous entry memory with read-modify-write, plus total usage and peak registers
// depends on ptup_pkg
//
// Usage: events enter on the input channel (i_valid, o_stall, i_item) and
// each event gives exactly one result on the output channel (o_valid,
// i_stall, o_result). A transfer happens on a rising edge with valid high
// and stall low.
// Timing: the entry memory is read at the edge that takes the event; the entry
// is updated, written back and the result register loaded at the edge that
// ends the update, which a stalled, full result register can hold back.
// Events are taken one at a time: the next waits until the last update is
// done, set by the single-port read then write of the entry memory.
// The result register parts the channels: a new event is taken while a
// finished result still waits. If the receiver stalls and the result
// register is still full when the next update is ready, the update waits
// and o_stall stays high until the result register is free.
// Reset clears the totals and the per-entry valid flags at once, so every
// entry reads as zero after reset; no clearing pass is needed.
`default_nettype none

module per_task_usage_peak_table_core
    import ptup_pkg::*;
#(
    parameter int unsigned TASK_ENTRIES = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_result
);

    localparam int unsigned IDX_W = (TASK_ENTRIES > 1) ? $clog2(TASK_ENTRIES) : 1;
    localparam logic [ID_W:0] LAST_ID = (ID_W+1)'(TASK_ENTRIES - 1);
    localparam logic [AMT_W-1:0] SAT_MAX = {AMT_W{1'b1}};

    // state
    t_entry                  r_mem [TASK_ENTRIES];
    logic [TASK_ENTRIES-1:0] r_valid;
    t_entry                  r_rd_entry;
    logic                    r_rd_valid;
    logic                    r_busy;
    t_in_item                r_op;
    logic [IDX_W-1:0]        r_idx;
    logic [AMT_W-1:0]        r_sum_used;
    logic [AMT_W-1:0]        r_sum_peak;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    accept;
    logic                    done;
    logic                    out_xfer;
    logic [IDX_W-1:0]        in_idx;
    logic [AMT_W-1:0]        cur_used;
    logic [AMT_W-1:0]        cur_peak;
    logic [AMT_W:0]          ent_sum;
    logic [AMT_W:0]          tot_sum;
    logic [AMT_W-1:0]        inc_used;
    logic [AMT_W-1:0]        inc_total;
    logic                    refuse;
    logic [AMT_W-1:0]        n_used;
    logic [AMT_W-1:0]        n_peak;
    logic [AMT_W-1:0]        n_sum_used;
    logic [AMT_W-1:0]        n_sum_peak;
    logic                    mem_we;

    // handshake
    assign accept   = i_valid && !r_busy;
    assign done     = r_busy && (!r_out_valid || !i_stall);
    assign out_xfer = r_out_valid && !i_stall;
    assign o_stall  = r_busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // clamp task id to the last entry
    always_comb begin
        if ({1'b0, i_item.task_id} > LAST_ID) begin
            in_idx = IDX_W'(LAST_ID);
        end else begin
            in_idx = IDX_W'(i_item.task_id);
        end
    end

    // entry read at transfer, entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_entry <= r_mem[in_idx];
            r_rd_valid <= r_valid[in_idx];
            r_op       <= i_item;
            r_idx      <= in_idx;
        end
    end

    assign cur_used = r_rd_valid ? r_rd_entry.used : '0;
    assign cur_peak = r_rd_valid ? r_rd_entry.peak : '0;

    // saturating sums for increase
    assign ent_sum   = {1'b0, cur_used} + {1'b0, r_op.amount};
    assign tot_sum   = {1'b0, r_sum_used} + {1'b0, r_op.amount};
    assign inc_used  = ent_sum[AMT_W] ? SAT_MAX : ent_sum[AMT_W-1:0];
    assign inc_total = tot_sum[AMT_W] ? SAT_MAX : tot_sum[AMT_W-1:0];

    // entry and total update
    always_comb begin
        n_used     = cur_used;
        n_peak     = cur_peak;
        n_sum_used = r_sum_used;
        n_sum_peak = r_sum_peak;
        refuse     = 1'b0;
        mem_we     = 1'b0;
        case (r_op.mode)
            MODE_INC: begin
                mem_we     = 1'b1;
                n_used     = inc_used;
                n_peak     = (inc_used > cur_peak) ? inc_used : cur_peak;
                n_sum_used = inc_total;
                n_sum_peak = (inc_total > r_sum_peak) ? inc_total : r_sum_peak;
            end
            MODE_DEC: begin
                if (cur_used != '0 && cur_used < r_op.amount) begin
                    refuse = 1'b1;
                end else begin
                    mem_we     = 1'b1;
                    n_used     = (cur_used != '0) ? cur_used - r_op.amount : cur_used;
                    n_sum_used = (r_sum_used < r_op.amount) ? '0
                                                            : r_sum_used - r_op.amount;
                end
            end
            MODE_CLR: begin
                mem_we = 1'b1;
                n_used = '0;
                n_peak = '0;
            end
            default: begin
            end
        endcase
    end

    // write back entry
    always_ff @(posedge i_clk) begin
        if (done && mem_we) begin
            r_mem[r_idx] <= '{used: n_used, peak: n_peak};
        end
    end

    // control state and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_busy      <= 1'b0;
            r_sum_used  <= '0;
            r_sum_peak  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_sum_used <= n_sum_used;
                r_sum_peak <= n_sum_peak;
                if (mem_we) begin
                    r_valid[r_idx] <= 1'b1;
                end
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.task_used  <= n_used;
            r_out.task_peak  <= n_peak;
            r_out.total_used <= n_sum_used;
            r_out.total_peak <= n_sum_peak;
            r_out.refused    <= refuse;
        end
    end

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("event taken without starting an update");

    a_total_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_peak >= r_sum_used)
        else $error("total peak below total usage");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && !done) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

    a_refuse_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && refuse) |=> (r_sum_used == $past(r_sum_used)))
        else $error("refused decrease changed total usage");

    a_done_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && !r_busy))
        else $error("update finished without a result");

endmodule

`default_nettype wire
